// ----- hw/rtl/rp_pkg.sv -----
// shared constants and types for the byte to seven bit repacker
// no dependencies; imported by rp_pack, rp_out_buf and byte_to_seven_bit_repacker
package rp_pkg;

    localparam int ByteBits  = 8;
    localparam int GroupBits = 7;
    localparam int ResBits   = 6;
    localparam int CntBits   = 3;
    localparam int AccBits   = ByteBits + ResBits;

    localparam logic [ByteBits-1:0] MarkBit = 8'h80;

    // up to two coded bytes produced by one input byte
    typedef struct packed {
        logic [ByteBits-1:0] code0;
        logic                last0;
        logic [ByteBits-1:0] code1;
        logic                last1;
        logic                two;
    } t_pair;

endpackage

// ----- hw/rtl/rp_pack.sv -----
// combinational repacking of one byte against the residual bits
// depends on rp_pkg
module rp_pack (
    input  logic [7:0]             i_data,
    input  logic                   i_eom,
    input  logic [5:0]             i_res_bits,
    input  logic [2:0]             i_res_cnt,
    output rp_pkg::t_pair          o_pair,
    output logic [5:0]             o_res_bits,
    output logic [2:0]             o_res_cnt
);
    import rp_pkg::*;

    logic [CntBits-1:0] cnt;
    logic [CntBits-1:0] take;
    logic [ResBits:0]   res_mask;
    logic [AccBits-1:0] acc;
    logic [AccBits-1:0] rem_mask;
    logic [AccBits-1:0] shifted;
    logic [ResBits-1:0] rem;
    logic [GroupBits-1:0] pad;

    always_comb begin
        cnt      = (i_res_cnt > CntBits'(ResBits)) ? CntBits'(ResBits) : i_res_cnt;
        res_mask = ((ResBits+1)'(1) << cnt) - (ResBits+1)'(1);
        acc      = {i_res_bits & res_mask[ResBits-1:0], i_data};
        take     = cnt + CntBits'(1);
        rem_mask = (AccBits'(1) << take) - AccBits'(1);
        shifted  = acc >> take;
        rem      = acc[ResBits-1:0] & rem_mask[ResBits-1:0];
        // leftover bits left-aligned in a group, zeros below
        pad      = GroupBits'(rem) << (CntBits'(ResBits) - cnt);

        if (cnt == CntBits'(ResBits)) begin
            // six pending bits: the byte closes two groups
            o_pair.code0 = MarkBit | {1'b0, acc[AccBits-1:GroupBits]};
            o_pair.last0 = 1'b0;
            o_pair.code1 = MarkBit | {1'b0, acc[GroupBits-1:0]};
            o_pair.last1 = i_eom;
            o_pair.two   = 1'b1;
            o_res_bits   = '0;
            o_res_cnt    = '0;
        end else begin
            o_pair.code0 = MarkBit | {1'b0, shifted[GroupBits-1:0]};
            o_pair.last0 = 1'b0;
            o_pair.code1 = MarkBit | {1'b0, pad};
            o_pair.last1 = 1'b1;
            o_pair.two   = i_eom;
            o_res_bits   = i_eom ? '0 : rem;
            o_res_cnt    = i_eom ? '0 : take;
        end
    end

endmodule

// ----- hw/rtl/rp_out_buf.sv -----
// two-slot result register feeding the output stream one coded byte per cycle while i_take is high
// depends on rp_pkg
module rp_out_buf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  rp_pkg::t_pair i_pair,
    input  logic          i_take,
    output logic          o_room,
    output logic          o_valid,
    output logic [7:0]    o_code,
    output logic          o_last
);
    import rp_pkg::*;

    logic [1:0]          r_cnt, n_cnt;
    logic [ByteBits-1:0] r_code0, n_code0, r_code1, n_code1;
    logic                r_last0, n_last0, r_last1, n_last1;

    // a new pair fits when the slots drain this cycle
    assign o_room  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_take);
    assign o_valid = (r_cnt != 2'd0);
    assign o_code  = r_code0;
    assign o_last  = r_last0;

    always_comb begin
        n_cnt   = r_cnt;
        n_code0 = r_code0;
        n_last0 = r_last0;
        n_code1 = r_code1;
        n_last1 = r_last1;
        if (i_load) begin
            n_code0 = i_pair.code0;
            n_last0 = i_pair.last0;
            n_code1 = i_pair.code1;
            n_last1 = i_pair.last1;
            n_cnt   = i_pair.two ? 2'd2 : 2'd1;
        end else if (i_take) begin
            if (r_cnt == 2'd2) begin
                n_code0 = r_code1;
                n_last0 = r_last1;
                n_cnt   = 2'd1;
            end else begin
                n_cnt   = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code0 <= n_code0;
        r_last0 <= n_last0;
        r_code1 <= n_code1;
        r_last1 <= n_last1;
    end

endmodule

// ----- hw/rtl/byte_to_seven_bit_repacker.sv -----
// Byte to seven bit repacker: each input request carries one byte (msb first) and an
// end-of-message flag in tlast; each output request carries one coded byte, seven payload
// bits with bit 7 set, and tlast on the final coded byte of the message. A byte that
// completes two groups, or that ends a message with leftover bits, yields two outputs;
// otherwise one. The output side moves one coded byte per cycle while i_m_axis_tready is
// high. A new input is loaded only when the two-slot result register has room, so an input
// that yields two outputs holds the next one back. An accepted request is registered in the
// input stage, then loaded into the result register, which presents its first coded byte.
// depends on rp_pkg, rp_pack and rp_out_buf
module byte_to_seven_bit_repacker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // data_byte[7:0]
    input  logic       i_s_axis_tlast,   // end_of_message
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // coded_byte[7:0]
    output logic       o_m_axis_tlast    // final_output
);
    import rp_pkg::*;

    logic                r_in_valid, n_in_valid;
    logic [ByteBits-1:0] r_in_data;
    logic                r_in_eom;
    logic [ResBits-1:0]  r_res_bits, n_res_bits;
    logic [CntBits-1:0]  r_res_cnt, n_res_cnt;

    t_pair pair;
    logic  load;
    logic  room;
    logic  accept;
    logic  take;

    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign take            = o_m_axis_tvalid && i_m_axis_tready;
    assign load            = r_in_valid && room;
    assign o_s_axis_tready = !r_in_valid || load;

    rp_pack u_pack (
        .i_data     (r_in_data),
        .i_eom      (r_in_eom),
        .i_res_bits (r_res_bits),
        .i_res_cnt  (r_res_cnt),
        .o_pair     (pair),
        .o_res_bits (n_res_bits),
        .o_res_cnt  (n_res_cnt)
    );

    rp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_pair  (pair),
        .i_take  (take),
        .o_room  (room),
        .o_valid (o_m_axis_tvalid),
        .o_code  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (load) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_res_bits <= '0;
            r_res_cnt  <= '0;
        end else begin
            r_in_valid <= n_in_valid;
            if (load) begin
                r_res_bits <= n_res_bits;
                r_res_cnt  <= n_res_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_data <= i_s_axis_tdata;
            r_in_eom  <= i_s_axis_tlast;
        end
    end

    a_res_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_cnt <= CntBits'(ResBits))
        else $error("residual count above six");

    a_mark_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[ByteBits-1])
        else $error("coded byte without mark bit");

    a_eom_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_in_eom) |=> (r_res_cnt == '0) && o_m_axis_tvalid)
        else $error("end of message did not clear residual");

    a_held_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !load) |=> r_in_valid && $stable(r_in_data))
        else $error("pending input lost");

endmodule
